>>> sv/mwc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the mecanum wheel command generator.
package mwc_pkg;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 3;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_Z      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVER       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_GAIN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SPEED_GAIN  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_DUTY_CEIL   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_REV_MASK    = 3'd7;

	// request and command codes share one encoding
	localparam logic [1:0] REQ_OFF   = 2'd0;
	localparam logic [1:0] REQ_DUTY  = 2'd1;
	localparam logic [1:0] REQ_SPEED = 2'd2;
	localparam logic [1:0] KIND_NONE = 2'd0;

	typedef struct packed {
		logic [14:0] step_x;
		logic [14:0] step_y;
		logic [14:0] step_z;
		logic [14:0] lever;
		logic [15:0] duty_gain;
		logic [15:0] speed_gain;
		logic [14:0] duty_ceiling;
		logic [7:0]  rev_mask;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		step_x:       15'd82,
		step_y:       15'd41,
		step_z:       15'd164,
		lever:        15'd1975,
		duty_gain:    16'd12201,
		speed_gain:   16'd11549,
		duty_ceiling: 15'd31130,
		rev_mask:     8'd16
	};

	typedef struct packed {
		logic               en;
		logic signed [31:0] a;
		logic [15:0]        b;
	} mul_req_t;

	localparam int PROD_W = 49;

endpackage

>>> sv/mwc_cfg.sv
`timescale 1ns / 1ps
// Configuration register file.
module mwc_cfg (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [mwc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [mwc_pkg::CFG_DATA_W-1:0]   cfg_data,
	output mwc_pkg::cfg_t                    cfg
);
	import mwc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_STEP_X:     cfg_q.step_x       <= cfg_data[14:0];
				CFG_STEP_Y:     cfg_q.step_y       <= cfg_data[14:0];
				CFG_STEP_Z:     cfg_q.step_z       <= cfg_data[14:0];
				CFG_LEVER:      cfg_q.lever        <= cfg_data[14:0];
				CFG_DUTY_GAIN:  cfg_q.duty_gain    <= cfg_data;
				CFG_SPEED_GAIN: cfg_q.speed_gain   <= cfg_data;
				CFG_DUTY_CEIL:  cfg_q.duty_ceiling <= cfg_data[14:0];
				CFG_REV_MASK:   cfg_q.rev_mask     <= cfg_data[7:0];
				default:        cfg_q              <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

>>> sv/mwc_mul.sv
`timescale 1ns / 1ps
// Shared signed-by-unsigned multiplier with registered product.
module mwc_mul (
	input  logic                                clk,
	input  mwc_pkg::mul_req_t                   req,
	output logic signed [mwc_pkg::PROD_W-1:0]   prod
);
	import mwc_pkg::*;

	logic signed [PROD_W-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (req.en) begin
			prod_q <= PROD_W'(req.a * $signed({1'b0, req.b}));
		end
	end

	assign prod = prod_q;

endmodule

>>> sv/mwc_core.sv
`timescale 1ns / 1ps
// Slew limiter, wheel sum sequencer, rounding/saturation and output register.
module mwc_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  mwc_pkg::cfg_t                     cfg,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic signed [15:0]                target_vx,
	input  logic signed [15:0]                target_vy,
	input  logic signed [15:0]                target_wz,
	input  logic [1:0]                        req_type,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic signed [23:0]                wheel_one,
	output logic signed [23:0]                wheel_two,
	output logic signed [23:0]                wheel_three,
	output logic signed [23:0]                wheel_four,
	output logic [1:0]                        command_kind,
	output mwc_pkg::mul_req_t                 mul_req,
	input  logic signed [mwc_pkg::PROD_W-1:0] mul_prod
);
	import mwc_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_ROT, ST_ROTW, ST_WHEEL} state_t;

	localparam logic [2:0] WHEEL_LAST = 3'd4;
	localparam logic signed [PROD_W-1:0] DUTY_HALF = PROD_W'(1) <<< 24;
	localparam logic signed [PROD_W-1:0] SPD_HALF  = PROD_W'(1) <<< 23;
	localparam logic signed [PROD_W-1:0] SPD_MAX   = PROD_W'(24'sh7FFFFF);
	localparam logic signed [PROD_W-1:0] SPD_MIN   = -SPD_MAX - PROD_W'(1);

	function automatic logic signed [15:0] slew(input logic signed [15:0] cur,
			input logic signed [15:0] tgt, input logic [14:0] step);
		logic signed [16:0] d;
		logic signed [16:0] s;
		logic signed [16:0] nxt;
		d = {tgt[15], tgt} - {cur[15], cur};
		s = {2'b00, step};
		if (d > s) begin
			d = s;
		end else if (d < -s) begin
			d = -s;
		end
		nxt = {cur[15], cur} + d;
		return nxt[15:0];
	endfunction

	state_t                  state_q;
	logic [2:0]              cnt_q;
	logic                    out_valid_q;
	logic signed [15:0]      slewed_vx_q, slewed_vy_q, slewed_wz_q;
	logic [1:0]              mode_q;
	logic signed [31:0]      lin_a_q, lin_b_q, rot_q;
	logic signed [23:0]      res_q [3];
	logic signed [23:0]      wheel_q [4];
	logic [1:0]              kind_q;

	logic                    in_acc, last, out_free, neg;
	logic signed [31:0]      sum;
	logic signed [16:0]      dif, add;
	logic signed [PROD_W-1:0] rt, rs, ceil_w;
	logic signed [23:0]      rnd;
	logic [1:0]              kind;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign last     = (state_q == ST_WHEEL) && (cnt_q == WHEEL_LAST);
	assign out_free = !out_valid_q || out_ready;

	assign dif = {slewed_vx_q[15], slewed_vx_q} - {slewed_vy_q[15], slewed_vy_q};
	assign add = {slewed_vx_q[15], slewed_vx_q} + {slewed_vy_q[15], slewed_vy_q};

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    sum = lin_a_q - rot_q;
			2'd1:    sum = lin_b_q - rot_q;
			2'd2:    sum = lin_a_q + rot_q;
			default: sum = lin_b_q + rot_q;
		endcase
		case (mode_q)
			REQ_DUTY:  neg = cfg.rev_mask[{1'b0, cnt_q[1:0]}];
			REQ_SPEED: neg = cfg.rev_mask[{1'b1, cnt_q[1:0]}];
			default:   neg = 1'b0;
		endcase
	end

	always_comb begin
		mul_req.en = (state_q == ST_ROT) || ((state_q == ST_WHEEL) && !cnt_q[2]);
		if (state_q == ST_ROT) begin
			mul_req.a = 32'(slewed_wz_q);
			mul_req.b = {1'b0, cfg.lever};
		end else begin
			mul_req.a = neg ? -sum : sum;
			mul_req.b = (mode_q == REQ_DUTY) ? cfg.duty_gain : cfg.speed_gain;
		end
	end

	// round half up, then saturate per mode
	always_comb begin
		ceil_w = $signed({34'd0, cfg.duty_ceiling});
		rt     = '0;
		rs     = '0;
		kind   = KIND_NONE;
		case (mode_q) inside
			REQ_DUTY: begin
				rt = mul_prod + DUTY_HALF;
				rs = rt >>> 25;
				if (rs > ceil_w) begin
					rs = ceil_w;
				end else if (rs < -ceil_w) begin
					rs = -ceil_w;
				end
			end
			REQ_SPEED: begin
				rt = mul_prod + SPD_HALF;
				rs = rt >>> 24;
				if (rs > SPD_MAX) begin
					rs = SPD_MAX;
				end else if (rs < SPD_MIN) begin
					rs = SPD_MIN;
				end
			end
			default: rs = '0;
		endcase
		case (mode_q) inside
			REQ_DUTY, REQ_SPEED: kind = mode_q;
			default:             kind = KIND_NONE;
		endcase
		rnd = rs[23:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			slewed_vx_q <= '0;
			slewed_vy_q <= '0;
			slewed_wz_q <= '0;
		end else begin
			if (last && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						slewed_vx_q <= slew(slewed_vx_q, target_vx, cfg.step_x);
						slewed_vy_q <= slew(slewed_vy_q, target_vy, cfg.step_y);
						slewed_wz_q <= slew(slewed_wz_q, target_wz, cfg.step_z);
						state_q     <= ST_ROT;
					end
				end
				ST_ROT: state_q <= ST_ROTW;
				ST_ROTW: begin
					cnt_q   <= '0;
					state_q <= ST_WHEEL;
				end
				ST_WHEEL: begin
					if (!cnt_q[2]) begin
						cnt_q <= cnt_q + 3'd1;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= req_type;
		end
		if (state_q == ST_ROT) begin
			lin_a_q <= {{3{dif[16]}}, dif, 12'd0};
			lin_b_q <= {{3{add[16]}}, add, 12'd0};
		end
		if (state_q == ST_ROTW) begin
			rot_q <= mul_prod[31:0];
		end
		if ((state_q == ST_WHEEL) && (cnt_q != 3'd0) && !cnt_q[2]) begin
			res_q[2] <= rnd;
			res_q[1] <= res_q[2];
			res_q[0] <= res_q[1];
		end
		if (last && out_free) begin
			wheel_q[0] <= res_q[0];
			wheel_q[1] <= res_q[1];
			wheel_q[2] <= res_q[2];
			wheel_q[3] <= rnd;
			kind_q     <= kind;
		end
	end

	assign out_valid    = out_valid_q;
	assign wheel_one    = wheel_q[0];
	assign wheel_two    = wheel_q[1];
	assign wheel_three  = wheel_q[2];
	assign wheel_four   = wheel_q[3];
	assign command_kind = kind_q;

	logic signed [23:0] ceil_s;
	assign ceil_s = $signed({9'd0, cfg.duty_ceiling});

	a_slew_only_on_request: assert property (@(posedge clk) disable iff (!arst_n)
		!in_acc |=> $stable(slewed_vx_q) && $stable(slewed_vy_q) && $stable(slewed_wz_q))
		else $error("slewed state moved without a request");

	a_none_is_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == KIND_NONE) |->
		(wheel_q[0] == 24'sd0) && (wheel_q[1] == 24'sd0) &&
		(wheel_q[2] == 24'sd0) && (wheel_q[3] == 24'sd0))
		else $error("nonzero wheel command with no command kind");

	a_duty_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (kind_q == REQ_DUTY) |->
		(wheel_q[0] <= ceil_s) && (wheel_q[0] >= -ceil_s) &&
		(wheel_q[1] <= ceil_s) && (wheel_q[1] >= -ceil_s) &&
		(wheel_q[2] <= ceil_s) && (wheel_q[2] >= -ceil_s) &&
		(wheel_q[3] <= ceil_s) && (wheel_q[3] >= -ceil_s))
		else $error("duty command beyond ceiling");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		last && !out_free |=> (state_q == ST_WHEEL) && (cnt_q == WHEEL_LAST))
		else $error("sequencer left while output was busy");

endmodule

>>> sv/mecanum_wheel_command_generator.sv
`timescale 1ns / 1ps
// Top level: mecanum inverse kinematics with per-axis slew limiting.
// Each accepted request moves the three body velocities toward their targets by at most
// the programmed step, forms the four wheel sums and scales them to duty or deg/s (zero when off).
// A request occupies the block in order: it is accepted and slewed, the shared
// multiplier produces the lever-arm yaw term, and the same multiplier then
// scales the four wheel sums one per cycle while the previous product is rounded and
// saturated. in_ready is low until the sequencer is idle again. The result sits in an output
// register, so the next request can be accepted while it waits; if it is still unclaimed
// when the next result is ready, the sequencer holds until out_ready.
module mecanum_wheel_command_generator (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mwc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mwc_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [15:0]              target_vx,
	input  logic signed [15:0]              target_vy,
	input  logic signed [15:0]              target_wz,
	input  logic [1:0]                      req_type,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [23:0]              wheel_one,
	output logic signed [23:0]              wheel_two,
	output logic signed [23:0]              wheel_three,
	output logic signed [23:0]              wheel_four,
	output logic [1:0]                      command_kind
);
	import mwc_pkg::*;

	cfg_t                     cfg;
	mul_req_t                 mul_req;
	logic signed [PROD_W-1:0] mul_prod;

	mwc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mwc_mul u_mul (
		.clk  (clk),
		.req  (mul_req),
		.prod (mul_prod)
	);

	mwc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.target_vx    (target_vx),
		.target_vy    (target_vy),
		.target_wz    (target_wz),
		.req_type     (req_type),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.wheel_one    (wheel_one),
		.wheel_two    (wheel_two),
		.wheel_three  (wheel_three),
		.wheel_four   (wheel_four),
		.command_kind (command_kind),
		.mul_req      (mul_req),
		.mul_prod     (mul_prod)
	);

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the mecanum wheel command generator.
module testbench;
	import mwc_pkg::*;

	localparam logic [1:0] REQ_SPARE = 2'd3;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int SETTLE_CYCLES   = 12;
	localparam int HOLD_CYCLES     = 300;
	localparam int RANDOM_PHASES   = 8;
	localparam int ITEMS_PER_PHASE = 88;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER [8] = '{
		CFG_STEP_X, CFG_STEP_Y, CFG_STEP_Z, CFG_LEVER,
		CFG_DUTY_GAIN, CFG_SPEED_GAIN, CFG_DUTY_CEIL, CFG_REV_MASK
	};

	typedef struct packed {
		logic [3:0][23:0] wheel;
		logic [1:0]       kind;
	} wheel_cmd_t;

	typedef struct packed {
		logic                 is_cfg;
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0]          data;
		logic signed [15:0]   vx, vy, wz;
		logic [1:0]           rt;
		logic                 known;
		wheel_cmd_t           want;
	} step_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic signed [15:0]    target_vx = '0;
	logic signed [15:0]    target_vy = '0;
	logic signed [15:0]    target_wz = '0;
	logic [1:0]            req_type = REQ_OFF;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic signed [23:0]    wheel_one, wheel_two, wheel_three, wheel_four;
	logic [1:0]            command_kind;

	cfg_t               model_cfg = CFG_RESET;
	logic signed [15:0] body_vx = '0;
	logic signed [15:0] body_vy = '0;
	logic signed [15:0] body_wz = '0;
	wheel_cmd_t         pending_cmds [$];
	string              wheel_names [4] = '{"wheel_one", "wheel_two", "wheel_three", "wheel_four"};

	int errors = 0;
	int sent = 0;
	int checked = 0;
	int reg_writes = 0;
	int sender_idle_pct = 0;
	int receiver_stall_pct = 0;
	bit hold_request = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	mecanum_wheel_command_generator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.target_vx    (target_vx),
		.target_vy    (target_vy),
		.target_wz    (target_wz),
		.req_type     (req_type),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.wheel_one    (wheel_one),
		.wheel_two    (wheel_two),
		.wheel_three  (wheel_three),
		.wheel_four   (wheel_four),
		.command_kind (command_kind)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic signed [15:0] slew_toward(input logic signed [15:0] cur,
			input logic signed [15:0] tgt, input logic [14:0] step);
		int d;
		int s;
		int r;
		d = int'(tgt) - int'(cur);
		s = int'(step);
		if (d > s) d = s;
		else if (d < -s) d = -s;
		r = int'(cur) + d;
		return r[15:0];
	endfunction

	// round half up, then saturate
	function automatic logic [23:0] scale_wheel(input longint sum, input logic [15:0] gain,
			input int shift, input longint lim_lo, input longint lim_hi);
		longint r;
		r = (sum * longint'(gain) + (64'sd1 <<< (shift - 1))) >>> shift;
		if (r < lim_lo) r = lim_lo;
		if (r > lim_hi) r = lim_hi;
		return r[23:0];
	endfunction

	function automatic wheel_cmd_t next_wheel_cmd(input logic signed [15:0] tx,
			input logic signed [15:0] ty, input logic signed [15:0] tz, input logic [1:0] rt);
		wheel_cmd_t cmd;
		longint lin_a, lin_b, rot, s;
		longint sums [4];
		int k;
		body_vx = slew_toward(body_vx, tx, model_cfg.step_x);
		body_vy = slew_toward(body_vy, ty, model_cfg.step_y);
		body_wz = slew_toward(body_wz, tz, model_cfg.step_z);
		lin_a = (longint'(body_vx) - longint'(body_vy)) * 4096;
		lin_b = (longint'(body_vx) + longint'(body_vy)) * 4096;
		rot = longint'(model_cfg.lever) * longint'(body_wz);
		sums[0] = lin_a - rot;
		sums[1] = lin_b - rot;
		sums[2] = lin_a + rot;
		sums[3] = lin_b + rot;
		cmd.wheel = '0;
		cmd.kind = KIND_NONE;
		for (k = 0; k < 4; k++) begin
			s = sums[k];
			if (rt == REQ_DUTY) begin
				if (model_cfg.rev_mask[k]) s = -s;
				cmd.wheel[k] = scale_wheel(s, model_cfg.duty_gain, 25,
					-longint'(model_cfg.duty_ceiling), longint'(model_cfg.duty_ceiling));
			end else if (rt == REQ_SPEED) begin
				if (model_cfg.rev_mask[k + 4]) s = -s;
				cmd.wheel[k] = scale_wheel(s, model_cfg.speed_gain, 24, -64'sd8388608,
					64'sd8388607);
			end
		end
		if (rt == REQ_DUTY || rt == REQ_SPEED) cmd.kind = rt;
		return cmd;
	endfunction

	function automatic step_row_t reg_row(input logic [CFG_IDX_W-1:0] idx,
			input logic [15:0] data);
		step_row_t row;
		row = '0;
		row.is_cfg = 1'b1;
		row.idx = idx;
		row.data = data;
		return row;
	endfunction

	function automatic step_row_t tick_row(input logic signed [15:0] vx,
			input logic signed [15:0] vy, input logic signed [15:0] wz, input logic [1:0] rt);
		step_row_t row;
		row = '0;
		row.vx = vx;
		row.vy = vy;
		row.wz = wz;
		row.rt = rt;
		return row;
	endfunction

	// row whose wheels are plainly all zero
	function automatic step_row_t zero_row(input logic signed [15:0] vx,
			input logic signed [15:0] vy, input logic signed [15:0] wz, input logic [1:0] rt,
			input logic [1:0] kind);
		step_row_t row;
		row = tick_row(vx, vy, wz, rt);
		row.known = 1'b1;
		row.want.kind = kind;
		return row;
	endfunction

	function automatic logic signed [15:0] pick_target();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			2, 3, 4: return 16'($urandom_range(600) - 300);
			default: return 16'($urandom());
		endcase
	endfunction

	function automatic logic [1:0] pick_mode();
		case ($urandom_range(9))
			0: return REQ_OFF;
			1: return REQ_SPARE;
			2, 3, 4, 5: return REQ_DUTY;
			default: return REQ_SPEED;
		endcase
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_STEP_X:     model_cfg.step_x = data[14:0];
			CFG_STEP_Y:     model_cfg.step_y = data[14:0];
			CFG_STEP_Z:     model_cfg.step_z = data[14:0];
			CFG_LEVER:      model_cfg.lever = data[14:0];
			CFG_DUTY_GAIN:  model_cfg.duty_gain = data;
			CFG_SPEED_GAIN: model_cfg.speed_gain = data;
			CFG_DUTY_CEIL:  model_cfg.duty_ceiling = data[14:0];
			CFG_REV_MASK:   model_cfg.rev_mask = data[7:0];
			default: ;
		endcase
		reg_writes++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_cmds.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic offer(input logic signed [15:0] vx, input logic signed [15:0] vy,
			input logic signed [15:0] wz, input logic [1:0] rt, input logic known,
			input wheel_cmd_t want);
		wheel_cmd_t cmd;
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		target_vx <= vx;
		target_vy <= vy;
		target_wz <= wz;
		req_type <= rt;
		do @(posedge clk); while (!in_ready);
		cmd = next_wheel_cmd(vx, vy, wz, rt);
		pending_cmds = {pending_cmds, (known ? want : cmd)};
		sent++;
		@(negedge clk);
	endtask

	task automatic shuffle_regs();
		int i;
		logic [15:0] v;
		for (i = 0; i < 8; i++) begin
			case ($urandom_range(7))
				0: v = '0;
				1: v = 16'hFFFF;
				2, 3: v = 16'($urandom_range(400));
				default: v = 16'($urandom());
			endcase
			set_reg(REG_ORDER[i], v);
		end
	endtask

	always @(negedge clk) begin
		if (hold_request) begin
			hold_request = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= receiver_stall_pct);
		end
	end

	always @(posedge clk) begin : check_cmds
		wheel_cmd_t want;
		logic [3:0][23:0] got;
		int k;
		if (arst_n && out_valid && out_ready) begin
			got = {wheel_four, wheel_three, wheel_two, wheel_one};
			if (pending_cmds.size() == 0) begin
				errors++;
				$display("%0t unexpected command: expected none, got %0d %0d %0d %0d kind %0d",
					$time, wheel_one, wheel_two, wheel_three, wheel_four, command_kind);
			end else begin
				want = pending_cmds.pop_front();
				checked++;
				for (k = 0; k < 4; k++) begin
					if (got[k] !== want.wheel[k]) begin
						errors++;
						$display("%0t %s: expected %0d, got %0d", $time, wheel_names[k],
							$signed(want.wheel[k]), $signed(got[k]));
					end
				end
				if (command_kind !== want.kind) begin
					errors++;
					$display("%0t command_kind: expected %0d, got %0d", $time, want.kind,
						command_kind);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no handshake for %0d cycles", $time, quiet_cycles);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		step_row_t rows [$];
		int i, p, n, j, run;
		logic signed [15:0] tx, ty, tz;

		// reset state, disabled and spare selectors
		rows = {rows, zero_row(16'sd0, 16'sd0, 16'sd0, REQ_OFF, KIND_NONE)};
		rows = {rows, zero_row(16'sd0, 16'sd0, 16'sd0, REQ_DUTY, REQ_DUTY)};
		rows = {rows, zero_row(16'sd0, 16'sd0, 16'sd0, REQ_SPEED, REQ_SPEED)};
		rows = {rows, zero_row(16'sh7FFF, 16'sh8000, 16'sh7FFF, REQ_SPARE, KIND_NONE)};
		rows = {rows, zero_row(16'sh8000, 16'sh7FFF, 16'sh8000, REQ_OFF, KIND_NONE)};
		rows = {rows, tick_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, REQ_DUTY)};
		rows = {rows, tick_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, REQ_SPEED)};
		// widest steps, lever and gains
		rows = {rows, reg_row(CFG_STEP_X, 16'h7FFF)};
		rows = {rows, reg_row(CFG_STEP_Y, 16'h7FFF)};
		rows = {rows, reg_row(CFG_STEP_Z, 16'h7FFF)};
		rows = {rows, reg_row(CFG_LEVER, 16'h7FFF)};
		rows = {rows, reg_row(CFG_DUTY_GAIN, 16'hFFFF)};
		rows = {rows, reg_row(CFG_SPEED_GAIN, 16'hFFFF)};
		rows = {rows, reg_row(CFG_REV_MASK, 16'h00A5)};
		rows = {rows, tick_row(16'sh7FFF, 16'sh8000, 16'sh8000, REQ_DUTY)};
		rows = {rows, tick_row(16'sh7FFF, 16'sh8000, 16'sh8000, REQ_DUTY)};
		rows = {rows, tick_row(16'sh8000, 16'sh7FFF, 16'sh7FFF, REQ_SPEED)};
		rows = {rows, tick_row(16'sh8000, 16'sh7FFF, 16'sh7FFF, REQ_SPEED)};
		rows = {rows, tick_row(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, REQ_SPEED)};
		rows = {rows, reg_row(CFG_REV_MASK, 16'h005A)};
		rows = {rows, tick_row(16'sh8000, 16'sh8000, 16'sh8000, REQ_DUTY)};
		rows = {rows, tick_row(-16'sd1, 16'sd1, -16'sd1, REQ_SPEED)};
		// zero ceiling forces zero duty
		rows = {rows, reg_row(CFG_DUTY_CEIL, 16'h0000)};
		rows = {rows, zero_row(16'sh7FFF, 16'sh8000, 16'sh7FFF, REQ_DUTY, REQ_DUTY)};
		// zero steps hold every axis
		rows = {rows, reg_row(CFG_STEP_X, 16'h0000)};
		rows = {rows, reg_row(CFG_STEP_Y, 16'h0000)};
		rows = {rows, reg_row(CFG_STEP_Z, 16'h0000)};
		rows = {rows, tick_row(16'sh8000, 16'sh8000, 16'sh8000, REQ_SPEED)};
		rows = {rows, zero_row(16'sd0, 16'sd0, 16'sd0, REQ_DUTY, REQ_DUTY)};
		rows = {rows, reg_row(CFG_LEVER, 16'h0000)};
		rows = {rows, reg_row(CFG_SPEED_GAIN, 16'h0000)};
		rows = {rows, zero_row(16'sh8000, 16'sh7FFF, 16'sd0, REQ_SPEED, REQ_SPEED)};
		rows = {rows, tick_row(16'sh8000, 16'sh7FFF, 16'sd0, REQ_DUTY)};
		// back to power-up values
		rows = {rows, reg_row(CFG_STEP_X, 16'(CFG_RESET.step_x))};
		rows = {rows, reg_row(CFG_STEP_Y, 16'(CFG_RESET.step_y))};
		rows = {rows, reg_row(CFG_STEP_Z, 16'(CFG_RESET.step_z))};
		rows = {rows, reg_row(CFG_LEVER, 16'(CFG_RESET.lever))};
		rows = {rows, reg_row(CFG_DUTY_GAIN, CFG_RESET.duty_gain)};
		rows = {rows, reg_row(CFG_SPEED_GAIN, CFG_RESET.speed_gain)};
		rows = {rows, reg_row(CFG_DUTY_CEIL, 16'(CFG_RESET.duty_ceiling))};
		rows = {rows, reg_row(CFG_REV_MASK, 16'(CFG_RESET.rev_mask))};
		rows = {rows, tick_row(16'sd100, -16'sd100, 16'sd50, REQ_DUTY)};
		rows = {rows, tick_row(-16'sd20000, 16'sd15000, 16'sd9000, REQ_SPEED)};

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (i = 0; i < rows.size(); i++) begin
			if (rows[i].is_cfg) begin
				wait_idle();
				set_reg(rows[i].idx, rows[i].data);
			end else begin
				offer(rows[i].vx, rows[i].vy, rows[i].wz, rows[i].rt, rows[i].known,
					rows[i].want);
			end
		end

		for (p = 0; p < RANDOM_PHASES; p++) begin
			wait_idle();
			shuffle_regs();
			case (p % 4)
				0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
				1: begin sender_idle_pct = 88; receiver_stall_pct = 0;  end
				2: begin sender_idle_pct = 0;  receiver_stall_pct = 88; end
				default: begin sender_idle_pct = 28; receiver_stall_pct = 28; end
			endcase
			// long receiver hold-off while requests keep coming
			if (p == 0) hold_request = 1'b1;
			n = 0;
			while (n < ITEMS_PER_PHASE) begin
				tx = pick_target();
				ty = pick_target();
				tz = pick_target();
				run = $urandom_range(12, 1);
				for (j = 0; j < run && n < ITEMS_PER_PHASE; j++) begin
					offer(tx, ty, tz, pick_mode(), 1'b0, '0);
					n++;
				end
			end
		end

		wait_idle();
		$display("summary: %0d requests sent, %0d commands checked, %0d register writes,",
			sent, checked, reg_writes);
		$display("summary: directed table plus %0d random phases with mixed stalls",
			RANDOM_PHASES);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
